### rtl/core/rmrl_pkg.sv
// Shared types and constants for the repeat message rate limiter.
package rmrl_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    typedef struct packed {
        logic [31:0] message_key;
        logic [31:0] hold_ms;
        logic [31:0] now_ms;
    } req_t;

    typedef struct packed {
        logic pass;
        logic oldest_dropped;
    } rsp_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] start_ms;
        logic [31:0] hold_ms;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND,
        ST_RESULT
    } state_t;

endpackage

### rtl/core/repeat_message_rate_limiter_unit.sv
// Top level of the repeat message rate limiter: sequencer, entry table, output register.
// The search reads one table entry per cycle, oldest first, until a match or the last filled entry;
// on a miss the item is then appended, and the oldest entry is dropped when the table is full.
// A new item is taken only after the last result has been accepted by the output register.
// Reset clears the table to empty at once; entry contents need no clearing.
module repeat_message_rate_limiter_unit
    import rmrl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic             res_valid;
    logic             res_take;
    rsp_t             res;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    rmrl_table_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    rmrl_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    assign res_take  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            rsp_reg <= res;
        end
    end

endmodule

### rtl/core/rmrl_table_mem.sv
// Entry table memory: one write port, one registered read port.
module rmrl_table_mem
    import rmrl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output entry_t                         rd_data,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  entry_t                         wr_data
);

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/rmrl_ctrl.sv
// Search, update and append sequencer with ring pointer and fill count.
module rmrl_ctrl
    import rmrl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  req_t                           req,
    output logic                           res_valid,
    input  logic                           res_take,
    output rsp_t                           res,
    output logic                           rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    input  entry_t                         rd_data,
    output logic                           wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    output entry_t                         wr_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    state_t            state_reg, state_next;
    req_t              item_reg, item_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  oldest_reg, oldest_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    rsp_t              res_reg, res_next;

    logic              match;
    logic              expired;
    logic              last;
    logic              full;
    logic [IDX_W-1:0]  slot_inc;
    logic [IDX_W-1:0]  oldest_inc;
    logic [SUM_W-1:0]  tail_sum;
    logic [SUM_W-1:0]  tail_wrap;
    logic [31:0]       elapsed;

    assign match      = (rd_data.key == item_reg.message_key);
    assign elapsed    = item_reg.now_ms - rd_data.start_ms;
    assign expired    = (elapsed >= rd_data.hold_ms);
    assign last       = (CNT_W'(cnt_reg + 1'b1) == fill_reg);
    assign full       = (fill_reg == CNT_W'(TABLE_DEPTH));
    assign slot_inc   = (slot_reg == IDX_W'(TABLE_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    assign oldest_inc = (oldest_reg == IDX_W'(TABLE_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
    assign tail_sum   = {1'b0, oldest_reg} + SUM_W'(fill_reg);
    assign tail_wrap  = (tail_sum >= SUM_W'(TABLE_DEPTH)) ? tail_sum - SUM_W'(TABLE_DEPTH)
                                                           : tail_sum;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (fill_reg == '0) ? ST_APPEND : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    state_next = ST_RESULT;
                end
                else if (last)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall   = (state_reg != ST_IDLE);
        res_valid   = (state_reg == ST_RESULT);
        res         = res_reg;
        rd_en       = 1'b0;
        rd_addr     = oldest_reg;
        wr_en       = 1'b0;
        wr_addr     = slot_reg;
        wr_data     = '{key: item_reg.message_key, start_ms: item_reg.now_ms,
                        hold_ms: item_reg.hold_ms};
        item_next   = item_reg;
        slot_next   = slot_reg;
        cnt_next    = cnt_reg;
        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        res_next    = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    rd_en     = 1'b1;
                    item_next = req;
                    slot_next = oldest_reg;
                    cnt_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    wr_en    = expired;
                    res_next = '{pass: expired, oldest_dropped: 1'b0};
                end
                else if (!last)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = slot_inc;
                    slot_next = slot_inc;
                    cnt_next  = CNT_W'(cnt_reg + 1'b1);
                end
            end
            ST_APPEND:
            begin
                wr_en = 1'b1;
                if (full)
                begin
                    wr_addr     = oldest_reg;
                    oldest_next = oldest_inc;
                    res_next    = '{pass: 1'b1, oldest_dropped: 1'b1};
                end
                else
                begin
                    wr_addr   = tail_wrap[IDX_W-1:0];
                    fill_next = CNT_W'(fill_reg + 1'b1);
                    res_next  = '{pass: 1'b1, oldest_dropped: 1'b0};
                end
            end
            ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            oldest_reg <= '0;
            fill_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            fill_reg   <= fill_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        slot_reg <= slot_next;
        res_reg  <= res_next;
    end

endmodule
